### design/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg: shared types and constants of the semiprime test unit
// Widths of the datapath, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package spt_pkg;

	// width of the tested number
	localparam int NUMBER_WIDTH = 16;
	// trial divisor: one past the square root of the largest number
	localparam int DIV_WIDTH    = (NUMBER_WIDTH + 1) / 2 + 1;
	// divisor squared
	localparam int SQ_WIDTH     = 2 * DIV_WIDTH;
	// divider partial remainder after the shift, before the subtract
	localparam int TRIAL_WIDTH  = DIV_WIDTH + 1;
	// quotient bit counter of the divider
	localparam int STEP_WIDTH   = $clog2(NUMBER_WIDTH);
	localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(NUMBER_WIDTH - 1);

	// factor count, saturating
	localparam int COUNT_WIDTH = 2;
	localparam logic [COUNT_WIDTH-1:0] COUNT_ZERO = 2'd0;
	localparam logic [COUNT_WIDTH-1:0] COUNT_TWO  = 2'd2;
	localparam logic [COUNT_WIDTH-1:0] COUNT_SAT  = 2'd3;

	// first trial divisor
	localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR = DIV_WIDTH'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_START,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} spt_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // take a new number, first divisor, clear count
		logic div_start;  // load the divider with the remaining value
		logic div_step;   // one quotient bit
		logic take;       // divisor divides: keep quotient, count a factor
		logic next_div;   // move to the next trial divisor
		logic finish;     // result goes to the output register
	} spt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic loop_go;    // fewer than two factors and divisor squared fits
		logic rem_zero;   // last division left no remainder
	} spt_sts_t;

endpackage

### design/spt_datapath.sv
// ----------------------------------------------------------------------------
// spt_datapath: trial division datapath
// Holds the remaining value, the trial divisor and the factor count, and a
// restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spt_datapath (
	input  logic                                 clk,
	input  logic [spt_pkg::NUMBER_WIDTH-1:0]     number,
	input  spt_pkg::spt_cmd_t                    cmd,
	output spt_pkg::spt_sts_t                    sts,
	output logic                                 is_semiprime,
	output logic [spt_pkg::COUNT_WIDTH-1:0]      factor_count
);
	import spt_pkg::*;

	logic [NUMBER_WIDTH-1:0] rest_q;
	logic [DIV_WIDTH-1:0]    div_q;
	logic [COUNT_WIDTH-1:0]  count_q;
	logic [NUMBER_WIDTH-1:0] quo_q;
	logic [DIV_WIDTH-1:0]    rem_q;

	logic [SQ_WIDTH-1:0]     div_sq;
	logic [TRIAL_WIDTH-1:0]  trial;
	logic [TRIAL_WIDTH-1:0]  diff;
	logic                    fits;
	logic                    rest_above_one;

	// loop condition of the divisor search
	always_comb begin
		div_sq       = SQ_WIDTH'(div_q) * SQ_WIDTH'(div_q);
		sts.loop_go  = (count_q < COUNT_TWO) && (div_sq <= SQ_WIDTH'(rest_q));
		sts.rem_zero = (rem_q == '0);
	end

	// restoring divider step: shift in the next dividend bit, try to subtract
	always_comb begin
		trial = {rem_q, quo_q[NUMBER_WIDTH-1]};
		diff  = trial - {1'b0, div_q};
		fits  = (trial >= {1'b0, div_q});
	end

	// search state and divider registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rest_q  <= number;
			div_q   <= FIRST_DIVISOR;
			count_q <= COUNT_ZERO;
		end else if (cmd.take) begin
			rest_q  <= quo_q;
			count_q <= (count_q == COUNT_SAT) ? COUNT_SAT : count_q + 1'b1;
		end else if (cmd.next_div) begin
			div_q   <= div_q + 1'b1;
		end

		if (cmd.div_start) begin
			quo_q <= rest_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[NUMBER_WIDTH-2:0], fits};
			rem_q <= fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
		end
	end

	// a remainder above one is one more prime
	always_comb begin
		rest_above_one = (rest_q[NUMBER_WIDTH-1:1] != '0);
		if (rest_above_one && (count_q != COUNT_SAT)) begin
			factor_count = count_q + 1'b1;
		end else begin
			factor_count = count_q;
		end
		is_semiprime = (factor_count == COUNT_TWO);
	end

endmodule

### design/spt_ctrl.sv
// ----------------------------------------------------------------------------
// spt_ctrl: semiprime test controller
// Sequences the divisor search: checks the loop condition, runs the divider
// for one quotient bit per cycle and strips factors until the search ends.
// ----------------------------------------------------------------------------
module spt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_free,
	input  spt_pkg::spt_sts_t sts,
	output spt_pkg::spt_cmd_t cmd
);
	import spt_pkg::*;

	spt_state_t             state_q;
	spt_state_t             state_next;
	logic [STEP_WIDTH-1:0]  step_q;

	// state register and quotient bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_START) begin
				step_q <= '0;
			end else if (state_q == ST_DIV) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_CHECK;
			end
			ST_CHECK: begin
				state_next = sts.loop_go ? ST_START : ST_DONE;
			end
			ST_START: begin
				state_next = ST_DIV;
			end
			ST_DIV: begin
				if (step_q == STEP_LAST) state_next = ST_UPDATE;
			end
			ST_UPDATE: begin
				// same divisor again after a hit, else the next one
				state_next = sts.rem_zero ? ST_START : ST_CHECK;
			end
			ST_DONE: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CHECK: begin
			end
			ST_START: begin
				cmd.div_start = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_UPDATE: begin
				cmd.take     = sts.rem_zero;
				cmd.next_div = !sts.rem_zero;
			end
			ST_DONE: begin
				cmd.finish = out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

### design/semiprime_test_unit.sv
// ----------------------------------------------------------------------------
// semiprime_test_unit: semiprime test by trial division
// Reports whether a number is the product of exactly two primes, counted
// with multiplicity, together with the number of prime factors found.
// ----------------------------------------------------------------------------
// One number is tested at a time. Each trial divisor runs a loop check, a
// divider load, one quotient bit per cycle in the shared restoring divider
// and an update, and each further copy of a factor that is stripped runs
// the divider load, the quotient bits and the update again; the divisor
// search ends at the square root of the remaining value or after two
// factors. The result sits in an output register, so the next number is
// taken while it waits.
module semiprime_test_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [spt_pkg::NUMBER_WIDTH-1:0]  number,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              is_semiprime,
	output logic [spt_pkg::COUNT_WIDTH-1:0]   factor_count
);
	import spt_pkg::*;

	spt_cmd_t               cmd;
	spt_sts_t               sts;
	logic                   out_free;
	logic                   res_semiprime;
	logic [COUNT_WIDTH-1:0] res_count;

	logic                   out_valid_q;
	logic                   is_semiprime_q;
	logic [COUNT_WIDTH-1:0] factor_count_q;

	spt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd)
	);

	spt_datapath u_datapath (
		.clk          (clk),
		.number       (number),
		.cmd          (cmd),
		.sts          (sts),
		.is_semiprime (res_semiprime),
		.factor_count (res_count)
	);

	// output beat register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			is_semiprime_q <= res_semiprime;
			factor_count_q <= res_count;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_semiprime = is_semiprime_q;
	assign factor_count = factor_count_q;

`ifndef SYNTHESIS
	// a result never overwrites a beat that is still waiting
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result loaded over a waiting beat");

	// the flag agrees with the count
	a_flag_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_semiprime == (factor_count == COUNT_TWO)))
		else $error("semiprime flag disagrees with factor count");

	// an accepted number keeps the input closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input open right after accepting a number");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of semiprime_test_unit
// Feeds 16-bit numbers over the valid/ready input channel and compares each
// output beat, field by field, with a trial-division predictor held in a
// small scoreboard. Both channels idle in random bursts; the last items run
// with no idling.
// ----------------------------------------------------------------------------
module tb_top;

	import spt_pkg::*;

	localparam int          RANDOM_ITEMS = 100;
	localparam int          CALM_ITEMS   = 25;
	localparam int          DRAIN_CYCLES = 100;
	localparam int unsigned CYCLE_LIMIT  = 4_000_000;

	typedef logic [NUMBER_WIDTH-1:0] number_t;

	// one expected output beat
	typedef struct {
		logic                   semi;
		logic [COUNT_WIDTH-1:0] factors;
	} verdict_t;

	// expected verdicts in order of acceptance, checked against output beats
	class semiprime_scoreboard;
		verdict_t    pending[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		// prime factors with multiplicity, search stops after two
		function int unsigned prime_factor_count(number_t value);
			int unsigned rest;
			int unsigned divisor;
			int unsigned found;
			rest    = value;
			divisor = 2;
			found   = 0;
			if (rest < 2)
				return 0;
			while (found < 2 && divisor * divisor <= rest) begin
				while (rest % divisor == 0) begin
					rest = rest / divisor;
					found++;
				end
				divisor++;
			end
			if (rest > 1)
				found++;
			return found;
		endfunction

		function void note_number(number_t value);
			verdict_t    v;
			int unsigned found;
			found     = prime_factor_count(value);
			v.semi    = (found == 2);
			v.factors = (found > 3) ? COUNT_SAT : COUNT_WIDTH'(found);
			pending.push_back(v);
		endfunction

		function void check_verdict(logic semi, logic [COUNT_WIDTH-1:0] factors);
			verdict_t v;
			if (pending.size() == 0) begin
				$error("output beat with nothing expected: is_semiprime=%0b factor_count=%0d",
					semi, factors);
				mismatches++;
				return;
			end
			v = pending.pop_front();
			if (semi !== v.semi) begin
				$error("is_semiprime: expected %0b, got %0b", v.semi, semi);
				mismatches++;
			end
			if (factors !== v.factors) begin
				$error("factor_count: expected %0d, got %0d", v.factors, factors);
				mismatches++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	number_t                number;
	logic                   out_valid;
	logic                   out_ready;
	logic                   is_semiprime;
	logic [COUNT_WIDTH-1:0] factor_count;

	semiprime_scoreboard sb;
	bit                  idling_on;
	int unsigned         cycle_count;
	int unsigned         stall_left;

	semiprime_test_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.number       (number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_semiprime (is_semiprime),
		.factor_count (factor_count)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// input beats feed the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_number(number);
	end

	// output beats are checked
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_verdict(is_semiprime, factor_count);
	end

	// receiver: random stall bursts while idling is on
	initial begin
		out_ready  = 1'b0;
		stall_left = 0;
		forever @(negedge clk) begin
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				out_ready  <= 1'b0;
				stall_left = $urandom_range(1, 17) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// present one number and hold it until the beat is taken
	task automatic send_number(input number_t value);
		@(negedge clk);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid <= 1'b1;
		number   <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid and wait for every outstanding verdict
	task automatic drain_verdicts();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// mix of full-range values, small values, products of two small
	// numbers and powers of two
	function automatic number_t random_number();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			return number_t'($urandom);
		else if (pick < 7)
			return number_t'($urandom_range(0, 1023));
		else if (pick < 9)
			return number_t'($urandom_range(2, 255) * $urandom_range(2, 255));
		else
			return number_t'(1 << $urandom_range(0, NUMBER_WIDTH - 1));
	endfunction

	// stimulus
	initial begin
		number_t directed[$];
		sb        = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		number    = '0;
		idling_on = 1'b1;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// zero and one, small primes and prime squares, early stop cases,
		// saturated counts, extremes of the range
		directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd8, 16'd9,
			16'd12, 16'd16, 16'd49, 16'd97, 16'd121, 16'd32767, 16'd32768,
			16'd63001, 16'd64507, 16'd65025, 16'd65521, 16'd65534, 16'd65535};
		foreach (directed[i])
			send_number(directed[i]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				drain_verdicts();
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				idling_on = 1'b0;
			send_number(random_number());
		end

		drain_verdicts();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
